// File: design/bss_pkg.sv
// Shared types and constants for the byte signature scanner.
// Holds the signature table, the result record and the fixed port widths.
// No dependencies.
package bss_pkg;

    localparam int SIG_COUNT   = 12;
    localparam int SIG_MAX_LEN = 6;
    localparam int WIN_DEPTH   = 5;
    localparam int ID_W        = 4;
    localparam int START_W     = 32;
    localparam int TOTAL_W     = 16;
    localparam int FILL_W      = 3;
    localparam int LEN_W       = 3;
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = 2;
    localparam int RES_CNT_W   = 3;

    typedef logic [7:0] byte_t;
    typedef logic [LEN_W-1:0] sig_len_t;

    // Length of each signature, in table order.
    localparam sig_len_t SIG_LEN [SIG_COUNT] = '{
        3'd3, 3'd4, 3'd2, 3'd6, 3'd4, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd4
    };

    // Signature bytes stored backwards: element 0 is the final byte of the
    // signature, element k is the byte k positions before it. Unused
    // elements are zero and never compared.
    localparam byte_t SIG_BYTES [SIG_COUNT][SIG_MAX_LEN] = '{
        '{8'h46, 8'h4C, 8'h45, 8'h00, 8'h00, 8'h00},
        '{8'h46, 8'h4C, 8'h45, 8'h7F, 8'h00, 8'h00},
        '{8'h5A, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h4E, 8'h45, 8'h52, 8'h44, 8'h41},
        '{8'h4D, 8'h4F, 8'h43, 8'h51, 8'h00, 8'h00},
        '{8'h4D, 8'h52, 8'h41, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00},
        '{8'h4C, 8'h53, 8'h47, 8'h4B, 8'h00, 8'h00},
        '{8'h55, 8'h50, 8'h47, 8'h00, 8'h00, 8'h00},
        '{8'hEF, 8'hBE, 8'hAD, 8'hDE, 8'h00, 8'h00},
        '{8'hBE, 8'hBA, 8'hFE, 8'hCA, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic [ID_W-1:0]    signature_id;
        logic [START_W-1:0] start_offset;
        logic [TOTAL_W-1:0] found_total;
        logic               last_of_run;
    } result_t;

endpackage

// File: design/byte_signature_scanner.sv
// Top level of the byte signature scanner: window, matcher and result queue.
// Depends on bss_pkg for the signature table and the result record.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+------------------------------------------
//  request  | byte_valid / byte_ready     | data_byte[7:0], end_of_data
//  result   | result_valid / result_ready | signature_id[3:0], start_offset[31:0],
//           |                             | found_total[15:0], last_of_run
//
// Each request byte is matched while it is offered, and its zero, one or two
// results are written into a four-entry result queue at the edge that accepts it.
// A result is queued the cycle after its byte is taken. The queue sends one result
// per cycle while result_ready is high, so requests run at one byte per cycle if
// each byte yields at most one result on average; the queue depth sets how far a
// burst of double hits or a stalled result side runs ahead before byte_ready drops.
// byte_ready is high whenever at least two queue entries are free.
// Reset empties the queue and clears the window, its fill count, the offset and
// the running match count.
module byte_signature_scanner
    import bss_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32,
    parameter int COUNT_WIDTH  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_data,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [ID_W-1:0]    signature_id,
    output logic [START_W-1:0] start_offset,
    output logic [TOTAL_W-1:0] found_total,
    output logic               last_of_run
);

    // Widths used to zero-extend or truncate internal values onto the ports.
    localparam int OFF_EXT_W = (OFFSET_WIDTH > START_W) ? OFFSET_WIDTH : START_W;
    localparam int CNT_EXT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Sliding window: element 0 is the byte just before the current one.
    byte_t                  win_reg [WIN_DEPTH];
    logic [FILL_W-1:0]      fill_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [COUNT_WIDTH-1:0] total_reg;

    // Result queue.
    result_t                res_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg;
    logic [RES_PTR_W-1:0]   rd_ptr_reg;
    logic [RES_CNT_W-1:0]   count_reg;

    logic                   accept;
    logic                   pop;
    byte_t                  cand [SIG_MAX_LEN];
    logic [SIG_COUNT-1:0]   hit;
    logic [ID_W-1:0]        first_id;
    logic [ID_W-1:0]        second_id;
    logic [1:0]             hit_count;
    logic [OFFSET_WIDTH-1:0] start0;
    logic [OFFSET_WIDTH-1:0] start1;
    logic [OFF_EXT_W-1:0]   start0_ext;
    logic [OFF_EXT_W-1:0]   start1_ext;
    logic [COUNT_WIDTH-1:0] total1;
    logic [COUNT_WIDTH-1:0] total2;
    logic [CNT_EXT_W-1:0]   total1_ext;
    logic [CNT_EXT_W-1:0]   total2_ext;
    logic [COUNT_WIDTH-1:0] total_next;
    result_t                res0;
    result_t                res1;
    logic [RES_CNT_W-1:0]   count_next;

    assign byte_ready   = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign accept       = byte_valid && byte_ready;
    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && result_ready;

    assign signature_id = res_mem[rd_ptr_reg].signature_id;
    assign start_offset = res_mem[rd_ptr_reg].start_offset;
    assign found_total  = res_mem[rd_ptr_reg].found_total;
    assign last_of_run  = res_mem[rd_ptr_reg].last_of_run;

    // The incoming byte followed by the window gives the candidate bytes that
    // line up with each signature read backwards from its final byte.
    always_comb
    begin
        cand[0] = data_byte;
        for (int k = 1; k < SIG_MAX_LEN; k++)
        begin
            cand[k] = win_reg[k-1];
        end
    end

    // All twelve signatures are compared in parallel. A signature longer than
    // the valid part of the current run cannot match.
    always_comb
    begin
        for (int p = 0; p < SIG_COUNT; p++)
        begin
            hit[p] = ({1'b0, fill_reg} + 4'd1) >= {1'b0, SIG_LEN[p]};
            for (int k = 0; k < SIG_MAX_LEN; k++)
            begin
                if (k < int'(SIG_LEN[p]) && cand[k] != SIG_BYTES[p][k])
                begin
                    hit[p] = 1'b0;
                end
            end
        end
    end

    // Pick the first two hits in table order.
    always_comb
    begin
        first_id  = '0;
        second_id = '0;
        hit_count = 2'd0;
        for (int p = 0; p < SIG_COUNT; p++)
        begin
            if (hit[p])
            begin
                if (hit_count == 2'd0)
                begin
                    first_id  = ID_W'(p);
                    hit_count = 2'd1;
                end
                else if (hit_count == 2'd1)
                begin
                    second_id = ID_W'(p);
                    hit_count = 2'd2;
                end
            end
        end
    end

    // Start offsets and saturating running totals for the two results.
    always_comb
    begin
        start0 = offset_reg - OFFSET_WIDTH'(SIG_LEN[first_id] - 3'd1);
        start1 = offset_reg - OFFSET_WIDTH'(SIG_LEN[second_id] - 3'd1);
        start0_ext = OFF_EXT_W'(start0);
        start1_ext = OFF_EXT_W'(start1);

        total1 = (total_reg == COUNT_MAX) ? COUNT_MAX : total_reg + 1'b1;
        total2 = (total1 == COUNT_MAX) ? COUNT_MAX : total1 + 1'b1;
        total1_ext = CNT_EXT_W'(total1);
        total2_ext = CNT_EXT_W'(total2);

        case (hit_count)
            2'd0:    total_next = total_reg;
            2'd1:    total_next = total1;
            default: total_next = total2;
        endcase

        res0.signature_id = first_id;
        res0.start_offset = start0_ext[START_W-1:0];
        res0.found_total  = total1_ext[TOTAL_W-1:0];
        res0.last_of_run  = (hit_count == 2'd1);

        res1.signature_id = second_id;
        res1.start_offset = start1_ext[START_W-1:0];
        res1.found_total  = total2_ext[TOTAL_W-1:0];
        res1.last_of_run  = 1'b1;

        count_next = count_reg;
        if (accept)
        begin
            count_next = count_next + RES_CNT_W'(hit_count);
        end
        if (pop)
        begin
            count_next = count_next - 1'b1;
        end
    end

    // Window, offset and running count. The final byte of a file is matched
    // normally and then the whole scan state returns to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                win_reg[k] <= '0;
            end
            fill_reg   <= '0;
            offset_reg <= '0;
            total_reg  <= '0;
        end
        else if (accept)
        begin
            if (end_of_data)
            begin
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    win_reg[k] <= '0;
                end
                fill_reg   <= '0;
                offset_reg <= '0;
                total_reg  <= '0;
            end
            else
            begin
                win_reg[0] <= data_byte;
                for (int k = 1; k < WIN_DEPTH; k++)
                begin
                    win_reg[k] <= win_reg[k-1];
                end
                if (fill_reg < FILL_W'(WIN_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                offset_reg <= offset_reg + 1'b1;
                total_reg  <= total_next;
            end
        end
    end

    // Result queue storage. Up to two entries are written per accepted byte.
    always_ff @(posedge clk)
    begin
        if (accept && hit_count != 2'd0)
        begin
            res_mem[wr_ptr_reg] <= res0;
            if (hit_count == 2'd2)
            begin
                res_mem[wr_ptr_reg + 1'b1] <= res1;
            end
        end
    end

    // Result queue pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(hit_count);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
